[hw/rtl/cfpb_pkg.sv]
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared types, register indexes and the CRC-16 byte update for the framed
// packet builder.
// ----------------------------------------------------------------------------
package cfpb_pkg;

  // Register indexes, decoded from paddr[3:2]
  localparam logic [1:0] REG_START_BYTE     = 2'd0;
  localparam logic [1:0] REG_END_BYTE       = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd2;
  localparam logic [1:0] REG_BOARD_ID       = 2'd3;

  // Item modes; the unused mode carries no meaning and is dropped
  localparam logic [1:0] MODE_START_SLOT  = 2'd0;
  localparam logic [1:0] MODE_START_BOARD = 2'd1;
  localparam logic [1:0] MODE_DATA        = 2'd2;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] slot;
    logic [7:0] command;
    logic [7:0] data_count;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [5:0] payload_length;
    logic [7:0] board_id;
  } cfg_t;

  // Which frame byte the datapath emits
  typedef enum logic [2:0] {
    SEL_SOF,
    SEL_ADDR,
    SEL_CMD,
    SEL_DATA,
    SEL_PAD,
    SEL_CRC_LO,
    SEL_CRC_HI,
    SEL_EOF
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic room;
    logic item_start;
    logic item_data;
    logic zero_expected;
    logic sent_lt_len;
    logic next_lt_len;
    logic data_done;
  } dp_status_t;

  // CRC-16/MODBUS update by one byte, reflected
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/crc16_framed_packet_builder.sv]
// ----------------------------------------------------------------------------
// crc16_framed_packet_builder
// Builds start / address / command / payload / CRC-16 / end frames byte by byte.
// ----------------------------------------------------------------------------
// A start item (mode 0 with its slot as address, mode 1 with board_id) opens a
// frame and emits start_byte, address and command. Each following data item
// (mode 2) emits one payload byte. When data_count bytes have been seen (the
// count is clamped to the effective payload length, payload_length saturated
// at MAX_PAYLOAD), the block pads with zeros up to that length, then sends the
// CRC-16/MODBUS of address, command and payload (init 0xFFFF, low byte first)
// and end_byte, marked by last. A zero count finishes the frame on the start
// item itself. A start during a frame drops the open frame silently; data
// outside a frame and mode 3 items are dropped. The block accepts an item while
// idle, then emits one byte per cycle through the output register whenever
// result_stall is low; an item that closes the frame also sends the padding
// bytes, the two CRC bytes and end_byte. The byte sequencer handles one
// item at a time and holds item_stall high while it emits. Configuration
// writes take effect at once and are meant to be done while the block is idle.
// ----------------------------------------------------------------------------
module crc16_framed_packet_builder
  import cfpb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 58
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers
  cfpb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: decides which byte goes out next and when to take an item
  cfpb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: CRC, counters, byte mux and the output register
  cfpb_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[hw/rtl/cfpb_regs.sv]
// ----------------------------------------------------------------------------
// cfpb_regs
// APB-style configuration registers of the framed packet builder.
// ----------------------------------------------------------------------------
module cfpb_regs
  import cfpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t regs;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_byte     <= 8'd2;
      regs.end_byte       <= 8'd3;
      regs.payload_length <= 6'd32;
      regs.board_id       <= 8'd0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_START_BYTE:     regs.start_byte     <= pwdata[7:0];
        REG_END_BYTE:       regs.end_byte       <= pwdata[7:0];
        REG_PAYLOAD_LENGTH: regs.payload_length <= pwdata[5:0];
        REG_BOARD_ID:       regs.board_id       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_BYTE:     prdata = {24'd0, regs.start_byte};
      REG_END_BYTE:       prdata = {24'd0, regs.end_byte};
      REG_PAYLOAD_LENGTH: prdata = {26'd0, regs.payload_length};
      REG_BOARD_ID:       prdata = {24'd0, regs.board_id};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/cfpb_datapath.sv]
// ----------------------------------------------------------------------------
// cfpb_datapath
// Item latch, CRC, byte counters, frame byte mux and output register.
// ----------------------------------------------------------------------------
module cfpb_datapath
  import cfpb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 58
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  item_t      item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  localparam logic [5:0] MaxLen = 6'(MAX_PAYLOAD);

  item_t       item_q;
  logic [15:0] crc;
  logic [5:0]  sent;
  logic [5:0]  expected;
  logic [5:0]  eff_len;
  logic [5:0]  sent_inc;
  logic [5:0]  clamped;
  logic [7:0]  addr_byte;
  logic [7:0]  byte_mux;
  logic        valid_q;
  result_t     result_q;

  assign eff_len   = (cfg.payload_length > MaxLen) ? MaxLen : cfg.payload_length;
  assign sent_inc  = sent + 6'd1;
  assign clamped   = (item_q.data_count > {2'b00, eff_len}) ? eff_len
                                                            : item_q.data_count[5:0];
  assign addr_byte = (item_q.mode == MODE_START_SLOT) ? item_q.slot : cfg.board_id;

  assign status.room          = !valid_q || !result_stall;
  assign status.item_start    = (item.mode == MODE_START_SLOT) ||
                                (item.mode == MODE_START_BOARD);
  assign status.item_data     = (item.mode == MODE_DATA);
  assign status.zero_expected = (expected == 6'd0);
  assign status.sent_lt_len   = (sent < eff_len);
  assign status.next_lt_len   = (sent_inc < eff_len);
  assign status.data_done     = (sent_inc >= expected);

  always_comb begin
    case (cmd.sel)
      SEL_SOF:    byte_mux = cfg.start_byte;
      SEL_ADDR:   byte_mux = addr_byte;
      SEL_CMD:    byte_mux = item_q.command;
      SEL_DATA:   byte_mux = item_q.data_byte;
      SEL_PAD:    byte_mux = 8'h00;
      SEL_CRC_LO: byte_mux = crc[7:0];
      SEL_CRC_HI: byte_mux = crc[15:8];
      SEL_EOF:    byte_mux = cfg.end_byte;
      default:    byte_mux = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_INIT;
      sent     <= 6'd0;
      expected <= 6'd0;
    end else if (cmd.emit) begin
      case (cmd.sel)
        SEL_SOF: begin
          crc      <= CRC_INIT;
          sent     <= 6'd0;
          expected <= clamped;
        end
        SEL_ADDR: crc <= crc_feed(crc, addr_byte);
        SEL_CMD:  crc <= crc_feed(crc, item_q.command);
        SEL_DATA: begin
          crc  <= crc_feed(crc, item_q.data_byte);
          sent <= sent_inc;
        end
        SEL_PAD: begin
          crc  <= crc_feed(crc, 8'h00);
          sent <= sent_inc;
        end
        SEL_EOF: crc <= CRC_INIT;
        default: ;
      endcase
    end
  end

  // Output register: load on emit, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (cmd.emit) begin
      valid_q <= 1'b1;
    end else if (!result_stall) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_q.frame_byte <= byte_mux;
      result_q.last       <= (cmd.sel == SEL_EOF);
    end
  end

  assign result_valid = valid_q;
  assign result       = result_q;

endmodule

[hw/rtl/cfpb_ctrl.sv]
// ----------------------------------------------------------------------------
// cfpb_ctrl
// Frame sequencer: walks through the bytes that one item causes.
// ----------------------------------------------------------------------------
module cfpb_ctrl
  import cfpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SOF    = 9'b000000010,
    ST_ADDR   = 9'b000000100,
    ST_CMD    = 9'b000001000,
    ST_DATA   = 9'b000010000,
    ST_PAD    = 9'b000100000,
    ST_CRC_LO = 9'b001000000,
    ST_CRC_HI = 9'b010000000,
    ST_EOF    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   frame_open, frame_open_next;
  logic   accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next      = state;
    frame_open_next = frame_open;
    cmd.load        = accept;
    cmd.emit        = 1'b0;
    cmd.sel         = SEL_SOF;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.item_start) begin
            state_next = ST_SOF;
          end else if (status.item_data && frame_open) begin
            state_next = ST_DATA;
          end
        end
      end
      ST_SOF: begin
        cmd.sel  = SEL_SOF;
        cmd.emit = status.room;
        if (status.room) begin
          frame_open_next = 1'b0;
          state_next      = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.sel  = SEL_ADDR;
        cmd.emit = status.room;
        if (status.room) begin
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        cmd.sel  = SEL_CMD;
        cmd.emit = status.room;
        if (status.room) begin
          if (!status.zero_expected) begin
            frame_open_next = 1'b1;
            state_next      = ST_IDLE;
          end else if (status.sent_lt_len) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_CRC_LO;
          end
        end
      end
      ST_DATA: begin
        cmd.sel  = SEL_DATA;
        cmd.emit = status.room;
        if (status.room) begin
          if (!status.data_done) begin
            state_next = ST_IDLE;
          end else if (status.next_lt_len) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_CRC_LO;
          end
        end
      end
      ST_PAD: begin
        cmd.sel  = SEL_PAD;
        cmd.emit = status.room;
        if (status.room && !status.next_lt_len) begin
          state_next = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        cmd.sel  = SEL_CRC_LO;
        cmd.emit = status.room;
        if (status.room) begin
          state_next = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        cmd.sel  = SEL_CRC_HI;
        cmd.emit = status.room;
        if (status.room) begin
          state_next = ST_EOF;
        end
      end
      ST_EOF: begin
        cmd.sel  = SEL_EOF;
        cmd.emit = status.room;
        if (status.room) begin
          frame_open_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      frame_open <= 1'b0;
    end else begin
      state      <= state_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

[hw/rtl/cfpb_checker.sv]
// ----------------------------------------------------------------------------
// cfpb_checker
// Port-level assertions for the framed packet builder.
// ----------------------------------------------------------------------------
module cfpb_checker
  import cfpb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result transfer holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

  // A start item always produces bytes, so the item side stalls next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall &&
    (item.mode == MODE_START_SLOT || item.mode == MODE_START_BOARD) |=> item_stall)
    else $error("start item did not start a frame");

  // An unused mode is dropped without stalling
  a_unused_drop: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.mode == MODE_UNUSED |=> !item_stall)
    else $error("unused mode item was not dropped");

endmodule

bind crc16_framed_packet_builder cfpb_checker u_cfpb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[verif/frame_checker.sv]
// ----------------------------------------------------------------------------
// frame_checker
// Watches the item, result and register ports of the packet builder, predicts
// every frame byte from the accepted items and compares the byte stream.
// ----------------------------------------------------------------------------
module frame_checker
  import cfpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_count,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] MODBUS_SEED   = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY_R = 16'hA001;
  localparam logic [5:0]  PAYLOAD_CAP   = 6'd58;

  // register shadow
  logic [7:0] cfg_start_byte;
  logic [7:0] cfg_end_byte;
  logic [5:0] cfg_payload_length;
  logic [7:0] cfg_board_id;

  // frame state
  logic        frame_open;
  logic [15:0] frame_crc;
  logic [5:0]  data_sent;
  logic [5:0]  data_expected;

  result_t expected_frame_bytes[$];
  int      errors = 0;

  // bit-serial form of the reflected CRC-16 update
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ MODBUS_POLY_R;
      end
    end
    return c;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic is_last);
    result_t r;
    r.frame_byte = b;
    r.last       = is_last;
    expected_frame_bytes.push_back(r);
  endfunction

  function automatic logic [5:0] capped_length();
    return (cfg_payload_length > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_payload_length;
  endfunction

  // zero padding up to the current length, then CRC low, CRC high, end byte
  function automatic void close_frame();
    logic [5:0] len;
    len = capped_length();
    while (data_sent < len) begin
      queue_byte(8'h00, 1'b0);
      frame_crc = modbus_crc_byte(frame_crc, 8'h00);
      data_sent = data_sent + 6'd1;
    end
    queue_byte(frame_crc[7:0], 1'b0);
    queue_byte(frame_crc[15:8], 1'b0);
    queue_byte(cfg_end_byte, 1'b1);
    frame_open = 1'b0;
    frame_crc  = MODBUS_SEED;
  endfunction

  function automatic void predict_frame_bytes(input item_t it);
    logic [7:0] addr;
    logic [5:0] len;
    case (it.mode)
      MODE_START_SLOT, MODE_START_BOARD: begin
        addr = (it.mode == MODE_START_SLOT) ? it.slot : cfg_board_id;
        len  = capped_length();
        // a start always abandons whatever frame is open
        frame_crc = MODBUS_SEED;
        queue_byte(cfg_start_byte, 1'b0);
        queue_byte(addr, 1'b0);
        frame_crc = modbus_crc_byte(frame_crc, addr);
        queue_byte(it.command, 1'b0);
        frame_crc = modbus_crc_byte(frame_crc, it.command);
        data_sent = 6'd0;
        data_expected = (it.data_count > {2'b00, len}) ? len : it.data_count[5:0];
        if (data_expected == 6'd0) begin
          close_frame();
        end else begin
          frame_open = 1'b1;
        end
      end
      MODE_DATA: begin
        if (frame_open) begin
          queue_byte(it.data_byte, 1'b0);
          frame_crc = modbus_crc_byte(frame_crc, it.data_byte);
          data_sent = data_sent + 6'd1;
          if (data_sent >= data_expected) begin
            close_frame();
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg_start_byte     = 8'd2;
      cfg_end_byte       = 8'd3;
      cfg_payload_length = 6'd32;
      cfg_board_id       = 8'd0;
      frame_open         = 1'b0;
      frame_crc          = MODBUS_SEED;
      data_sent          = 6'd0;
      data_expected      = 6'd0;
      expected_frame_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_START_BYTE:     cfg_start_byte     = pwdata[7:0];
          REG_END_BYTE:       cfg_end_byte       = pwdata[7:0];
          REG_PAYLOAD_LENGTH: cfg_payload_length = pwdata[5:0];
          REG_BOARD_ID:       cfg_board_id       = pwdata[7:0];
          default: begin
          end
        endcase
      end
      if (item_valid && !item_stall) begin
        predict_frame_bytes(item);
      end
      if (result_valid && !result_stall) begin
        if (expected_frame_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame byte: expected none, got %02h last %0b",
                   $time, result.frame_byte, result.last);
        end else begin
          want = expected_frame_bytes.pop_front();
          if (result.frame_byte !== want.frame_byte) begin
            errors++;
            $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                     $time, want.frame_byte, result.frame_byte);
          end
          if (result.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want.last, result.last);
          end
        end
      end
    end
    pending_count  <= expected_frame_bytes.size();
    mismatch_count <= errors;
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives items and register writes into the framed packet builder under
// several idle and stall mixes; frame_checker predicts and compares bytes.
// ----------------------------------------------------------------------------
module testbench
  import cfpb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PAYLOAD_MAX    = 58;
  localparam int         ITEMS_PER_PASS = 24;
  localparam int         SETTLE_CYCLES  = 10;
  // consecutive cycles without any transfer before the run is declared hung
  localparam int         STALL_LIMIT    = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending_count;
  int mismatch_count;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int length_setting = 32;
  int frame_items_sent = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crc16_framed_packet_builder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  frame_checker frame_chk (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  // Receiver: stall at random per the current mix, one decision per edge.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(input logic [1:0] m, input logic [7:0] s,
                                      input logic [7:0] c, input logic [7:0] n,
                                      input logic [7:0] d);
    item_t it;
    it.mode       = m;
    it.slot       = s;
    it.command    = c;
    it.data_count = n;
    it.data_byte  = d;
    return it;
  endfunction

  function automatic item_t random_item(input logic [1:0] m);
    return make_item(m, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Offer one item; hold it until the block takes the transfer. Returns at the
  // accepting edge, with valid still high so back-to-back items need no dip.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
  endtask

  // Drop valid and wait until every predicted byte has come out, then let the
  // block settle in case the last item produced nothing.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge.
  // The bus then goes idle before the task returns.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_PAYLOAD_LENGTH) begin
      length_setting = int'(value[5:0]);
    end
  endtask

  // One start item followed by the data it announces, sometimes cut short so
  // that the next start abandons the frame.
  task automatic random_frame();
    item_t hdr;
    int    cap;
    int    n;
    hdr = random_item($urandom_range(0, 1) ? MODE_START_BOARD : MODE_START_SLOT);
    if ($urandom_range(99) < 80) begin
      hdr.data_count = 8'($urandom_range(0, 8));
    end
    cap = (length_setting > PAYLOAD_MAX) ? PAYLOAD_MAX : length_setting;
    n   = (int'(hdr.data_count) > cap) ? cap : int'(hdr.data_count);
    if (n > 0 && $urandom_range(99) < 10) begin
      n = $urandom_range(0, n - 1);
    end
    send_item(hdr);
    frame_items_sent++;
    for (int k = 0; k < n; k++) begin
      send_item(random_item(MODE_DATA));
      frame_items_sent++;
    end
  endtask

  initial begin
    int pick;
    int stop_at;

    // Hold reset at the start, then release it once.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed part, no idling ----------------
    reg_write(REG_START_BYTE, 32'hFF);
    reg_write(REG_END_BYTE, 32'h00);
    reg_write(REG_PAYLOAD_LENGTH, 32'd3);
    reg_write(REG_BOARD_ID, 32'hA5);

    // zero count: the whole frame goes out on the start item
    send_item(make_item(MODE_START_SLOT, 8'hFF, 8'hFF, 8'h00, 8'hFF));
    // oversized count clamps to the payload length
    send_item(make_item(MODE_START_BOARD, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(MODE_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h5A));
    // short data, then zero padding
    send_item(make_item(MODE_START_SLOT, 8'h55, 8'hAA, 8'h02, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'hAA));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h55));
    // data with no frame open, and the unused mode: both dropped
    send_item(make_item(MODE_DATA, 8'h11, 8'h22, 8'h33, 8'h77));
    send_item(make_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // restart in the middle of a frame abandons it
    send_item(make_item(MODE_START_SLOT, 8'h0F, 8'hF0, 8'h03, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h01));
    send_item(make_item(MODE_START_BOARD, 8'h00, 8'h3C, 8'h01, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h12));
    // length shrinks while a frame is open: no padding once it is reached
    send_item(make_item(MODE_START_SLOT, 8'h80, 8'h01, 8'h03, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h80));
    drain();
    reg_write(REG_PAYLOAD_LENGTH, 32'd1);
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h01));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'hFE));
    drain();
    // length above the cap saturates
    reg_write(REG_PAYLOAD_LENGTH, 32'd63);
    send_item(make_item(MODE_START_SLOT, 8'h7E, 8'h81, 8'h00, 8'h00));
    drain();
    // zero length: frame with no payload
    reg_write(REG_PAYLOAD_LENGTH, 32'd0);
    send_item(make_item(MODE_START_SLOT, 8'h01, 8'h02, 8'h05, 8'h00));
    send_item(make_item(MODE_DATA, 8'h00, 8'h00, 8'h00, 8'h33));
    drain();

    // ---------------- random part, four idle/stall mixes ----------------
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin
          sender_idle_pct = 0;  receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 46; receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  receiver_stall_pct = 46;
        end
        default: begin
          sender_idle_pct = 38; receiver_stall_pct = 38;
        end
      endcase
      drain();
      case (pass)
        0: begin
          reg_write(REG_START_BYTE, $urandom_range(0, 255));
          reg_write(REG_END_BYTE, $urandom_range(0, 255));
          reg_write(REG_PAYLOAD_LENGTH, $urandom_range(2, 12));
          reg_write(REG_BOARD_ID, $urandom_range(0, 255));
        end
        1: begin
          reg_write(REG_START_BYTE, 32'h00);
          reg_write(REG_END_BYTE, 32'hFF);
          reg_write(REG_PAYLOAD_LENGTH, 32'd58);
          reg_write(REG_BOARD_ID, 32'h00);
        end
        2: begin
          reg_write(REG_START_BYTE, $urandom_range(0, 255));
          reg_write(REG_PAYLOAD_LENGTH, 32'd63);
          reg_write(REG_BOARD_ID, 32'hFF);
        end
        default: begin
          reg_write(REG_END_BYTE, $urandom_range(0, 255));
          reg_write(REG_PAYLOAD_LENGTH, $urandom_range(1, 6));
          reg_write(REG_BOARD_ID, $urandom_range(0, 255));
        end
      endcase

      stop_at = frame_items_sent + ITEMS_PER_PASS;
      while (frame_items_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          random_frame();
        end else if (pick < 88) begin
          // stray data: dropped unless a cut-short frame is still open
          send_item(random_item(MODE_DATA));
          frame_items_sent++;
        end else begin
          send_item(random_item(MODE_UNUSED));
          frame_items_sent++;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
